@@ src/frequency_ordered_id_cache_macros.svh @@
// ----------------------------------------------------------------------------
// Frequency-ordered ID cache assertion macros
// Shared assertion wrappers on clk_i and rst_ni.
// ----------------------------------------------------------------------------
`ifndef FREQUENCY_ORDERED_ID_CACHE_MACROS_SVH
`define FREQUENCY_ORDERED_ID_CACHE_MACROS_SVH

// check while out of reset
`define FOC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check at every edge, reset included
`define FOC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ src/foc_pkg.sv @@
// ----------------------------------------------------------------------------
// Frequency-ordered ID cache package
// Entry types, result codes and controller states.
// ----------------------------------------------------------------------------
package foc_pkg;

  localparam int unsigned IdentW  = 32;
  localparam int unsigned HitsW   = 16;
  localparam int unsigned HandleW = 16;
  localparam int unsigned SlotW   = 6;

  localparam logic [HitsW-1:0] HitsMax = '1;

  typedef enum logic [1:0] {
    OUT_ROOT  = 2'd0,
    OUT_HIT   = 2'd1,
    OUT_FILL  = 2'd2,
    OUT_UNRES = 2'd3
  } foc_outcome_e;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_LOOKUP = 1'b1
  } foc_state_e;

  typedef struct packed {
    logic [IdentW-1:0]  ident;
    logic [HitsW-1:0]   hits;
    logic [HandleW-1:0] handle;
  } foc_entry_t;

  typedef struct packed {
    logic       swap;
    foc_entry_t entry;
  } foc_up_t;

endpackage

@@ src/foc_req_if.sv @@
// ----------------------------------------------------------------------------
// Frequency-ordered ID cache request channel
// Valid/ready channel carrying one lookup request.
// ----------------------------------------------------------------------------
interface foc_req_if;
  logic                          valid;
  logic                          ready;
  logic [foc_pkg::IdentW-1:0]    ident;
  logic                          resolved;
  logic [foc_pkg::HandleW-1:0]   name_handle;

  modport source (output valid, ident, resolved, name_handle, input ready);
  modport sink   (input valid, ident, resolved, name_handle, output ready);
endinterface

@@ src/foc_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Frequency-ordered ID cache response channel
// Valid/ready channel carrying one lookup result.
// ----------------------------------------------------------------------------
interface foc_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    outcome;
  logic [foc_pkg::HandleW-1:0]   handle_out;
  logic [foc_pkg::SlotW-1:0]     slot;

  modport source (output valid, outcome, handle_out, slot, input ready);
  modport sink   (input valid, outcome, handle_out, slot, output ready);
endinterface

@@ src/frequency_ordered_id_cache.sv @@
// ----------------------------------------------------------------------------
// Frequency-ordered ID cache
// Self-organizing identifier table ordered by hit count, held in a row of
// cells that compare in parallel and trade places with their upper neighbor.
//
//   channel  dir  signals
//   req_i    in   valid ready ident resolved name_handle
//   rsp_o    out  valid ready outcome handle_out slot
//
// Each request is first registered; the compare, count update and neighbor
// swap across the cell row are then done when the result is committed.
// A request is taken while a finished result still waits in the output
// register; the update stalls only while that register is full and not taken.
// Reset clears the whole table at once; no clearing pass.
// ----------------------------------------------------------------------------
`include "frequency_ordered_id_cache_macros.svh"

module frequency_ordered_id_cache #(
  parameter int unsigned ENTRIES = 24
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  foc_req_if.sink   req_i,
  foc_rsp_if.source rsp_o
);

  foc_pkg::foc_state_e state_q, state_d;

  logic [foc_pkg::IdentW-1:0]  key_q;
  logic                        res_q;
  logic [foc_pkg::HandleW-1:0] hnd_q;

  logic                        req_acc;
  logic                        out_free;
  logic                        commit;
  logic                        key_valid;
  logic                        miss;
  logic                        fill;

  logic [ENTRIES:0]            hit_chain;
  logic [ENTRIES-1:0]          match_vec;
  logic [ENTRIES-1:0]          swap_vec;
  foc_pkg::foc_entry_t         entry_w [ENTRIES];
  foc_pkg::foc_up_t            up_w    [ENTRIES];
  foc_pkg::foc_entry_t         top_entry;
  foc_pkg::foc_entry_t         fill_entry;

  logic [foc_pkg::SlotW-1:0]   hit_slot;
  logic [foc_pkg::HandleW-1:0] hit_handle;

  logic                        out_valid_q, out_valid_d;
  foc_pkg::foc_outcome_e       outcome_q, outcome_d;
  logic [foc_pkg::HandleW-1:0] handle_q, handle_d;
  logic [foc_pkg::SlotW-1:0]   slot_q, slot_d;

  assign out_free  = !out_valid_q || rsp_o.ready;
  assign req_acc   = req_i.valid && req_i.ready;
  assign commit    = (state_q == foc_pkg::ST_LOOKUP) && out_free;
  assign key_valid = (key_q != '0);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      foc_pkg::ST_IDLE: begin
        if (req_acc) state_d = foc_pkg::ST_LOOKUP;
      end
      foc_pkg::ST_LOOKUP: begin
        if (commit) state_d = foc_pkg::ST_IDLE;
      end
      default: state_d = foc_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    unique case (state_q)
      foc_pkg::ST_IDLE:   req_i.ready = 1'b1;
      foc_pkg::ST_LOOKUP: req_i.ready = 1'b0;
      default:            req_i.ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= foc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
      res_q <= 1'b0;
      hnd_q <= '0;
    end else if (req_acc) begin
      key_q <= req_i.ident;
      res_q <= req_i.resolved;
      hnd_q <= req_i.name_handle;
    end
  end

  assign top_entry = '{ident: '0, hits: foc_pkg::HitsMax, handle: '0};
  assign fill_entry = '{ident: key_q, hits: foc_pkg::HitsW'(1), handle: hnd_q};
  assign hit_chain[0] = 1'b0;
  assign miss = !hit_chain[ENTRIES];
  assign fill = commit && key_valid && miss && res_q;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    foc_pkg::foc_entry_t above;
    foc_pkg::foc_up_t    below;
    logic                fill_here;

    if (g == 0) begin : g_top
      assign above = top_entry;
    end else begin : g_mid
      assign above = entry_w[g-1];
    end

    if (g == ENTRIES - 1) begin : g_last
      assign below     = '0;
      assign fill_here = fill;
    end else begin : g_rest
      assign below     = up_w[g+1];
      assign fill_here = 1'b0;
    end

    foc_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .update_i     (commit),
      .key_valid_i  (key_valid),
      .key_i        (key_q),
      .hit_above_i  (hit_chain[g]),
      .hit_chain_o  (hit_chain[g+1]),
      .match_o      (match_vec[g]),
      .above_i      (above),
      .below_i      (below),
      .fill_i       (fill_here),
      .fill_entry_i (fill_entry),
      .entry_o      (entry_w[g]),
      .up_o         (up_w[g])
    );

    assign swap_vec[g] = up_w[g].swap;
  end

  always_comb begin
    hit_slot   = '0;
    hit_handle = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match_vec[i]) begin
        hit_slot   = swap_vec[i] ? foc_pkg::SlotW'(i - 1) : foc_pkg::SlotW'(i);
        hit_handle = entry_w[i].handle;
      end
    end
  end

  always_comb begin
    if (!key_valid) begin
      outcome_d = foc_pkg::OUT_ROOT;
      handle_d  = '0;
      slot_d    = '0;
    end else if (!miss) begin
      outcome_d = foc_pkg::OUT_HIT;
      handle_d  = hit_handle;
      slot_d    = hit_slot;
    end else if (res_q) begin
      outcome_d = foc_pkg::OUT_FILL;
      handle_d  = hnd_q;
      slot_d    = foc_pkg::SlotW'(ENTRIES - 1);
    end else begin
      outcome_d = foc_pkg::OUT_UNRES;
      handle_d  = '0;
      slot_d    = '0;
    end
  end

  assign out_valid_d = commit ? 1'b1 : (rsp_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      outcome_q <= outcome_d;
      handle_q  <= handle_d;
      slot_q    <= slot_d;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.outcome    = outcome_q;
  assign rsp_o.handle_out = handle_q;
  assign rsp_o.slot       = slot_q;

  `FOC_ASSERT(a_single_match, $onehot0(match_vec), "more than one cell matched")
  `FOC_ASSERT(a_top_no_swap, !swap_vec[0], "top cell requested a swap")
  `FOC_ASSERT(a_commit_valid, commit |=> out_valid_q, "committed result not presented")
  `FOC_ASSERT_ALWAYS(a_swap_one, $onehot0(swap_vec), "more than one cell swapped")

endmodule

@@ src/foc_cell.sv @@
// ----------------------------------------------------------------------------
// Frequency-ordered ID cache cell
// One table slot: compare, saturating count, swap with upper neighbor, fill.
// ----------------------------------------------------------------------------
module foc_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       update_i,
  input  logic                       key_valid_i,
  input  logic [foc_pkg::IdentW-1:0] key_i,
  input  logic                       hit_above_i,
  output logic                       hit_chain_o,
  output logic                       match_o,
  input  foc_pkg::foc_entry_t        above_i,
  input  foc_pkg::foc_up_t           below_i,
  input  logic                       fill_i,
  input  foc_pkg::foc_entry_t        fill_entry_i,
  output foc_pkg::foc_entry_t        entry_o,
  output foc_pkg::foc_up_t           up_o
);

  foc_pkg::foc_entry_t          entry_q, entry_d;
  logic                         match;
  logic [foc_pkg::HitsW-1:0]    new_hits;
  logic                         swap;

  assign match       = key_valid_i && (entry_q.ident == key_i) && !hit_above_i;
  assign hit_chain_o = hit_above_i || match;
  assign match_o     = match;
  assign new_hits    = (entry_q.hits == foc_pkg::HitsMax) ? entry_q.hits
                                                          : entry_q.hits + 1'b1;
  assign swap        = match && (new_hits > above_i.hits);

  always_comb begin
    up_o.swap          = swap;
    up_o.entry.ident   = entry_q.ident;
    up_o.entry.hits    = new_hits;
    up_o.entry.handle  = entry_q.handle;
  end

  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (update_i) begin
      if (below_i.swap) begin
        entry_d = below_i.entry;
      end else if (swap) begin
        entry_d = above_i;
      end else if (match) begin
        entry_d.hits = new_hits;
      end else if (fill_i) begin
        entry_d = fill_entry_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

endmodule

@@ test/tb_frequency_ordered_id_cache.sv @@
// ----------------------------------------------------------------------------
// Frequency-ordered ID cache testbench
// Drives identifier lookups with random gaps on both channels and keeps its
// own copy of the hit-ordered table to predict each result. The run covers a
// directed opening, a random mix over a small identifier pool with a long
// output stall, and two full-rate bursts that walk single entries toward the top.
// ----------------------------------------------------------------------------
module tb_frequency_ordered_id_cache;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Entries    = 24;
  localparam int unsigned PoolSize   = 40;
  localparam int unsigned RandomReqs = 1420;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned SatHits    = 30;

  typedef struct packed {
    foc_pkg::foc_outcome_e       outcome;
    logic [foc_pkg::HandleW-1:0] handle;
    logic [foc_pkg::SlotW-1:0]   slot;
  } lookup_result_t;

  class lookup_scoreboard;
    foc_pkg::foc_entry_t rows[Entries];
    lookup_result_t      expected_results[$];
    int unsigned         mismatches;

    function new();
      foreach (rows[i]) rows[i] = '0;
      mismatches = 0;
    endfunction

    function void note_request(logic [foc_pkg::IdentW-1:0] ident, logic resolved,
                               logic [foc_pkg::HandleW-1:0] handle);
      lookup_result_t      r;
      foc_pkg::foc_entry_t t;
      int                  idx;
      r.outcome = foc_pkg::OUT_ROOT;
      r.handle  = '0;
      r.slot    = '0;
      if (ident != '0) begin
        idx = -1;
        for (int i = 0; i < Entries; i++) begin
          if (idx < 0 && rows[i].ident == ident) idx = i;
        end
        if (idx >= 0) begin
          if (rows[idx].hits != foc_pkg::HitsMax) rows[idx].hits = rows[idx].hits + 1'b1;
          if (idx > 0 && rows[idx].hits > rows[idx-1].hits) begin
            t            = rows[idx-1];
            rows[idx-1]  = rows[idx];
            rows[idx]    = t;
            idx          = idx - 1;
          end
          r.outcome = foc_pkg::OUT_HIT;
          r.handle  = rows[idx].handle;
          r.slot    = foc_pkg::SlotW'(idx);
        end else if (resolved) begin
          rows[Entries-1].ident  = ident;
          rows[Entries-1].hits   = foc_pkg::HitsW'(1);
          rows[Entries-1].handle = handle;
          r.outcome = foc_pkg::OUT_FILL;
          r.handle  = handle;
          r.slot    = foc_pkg::SlotW'(Entries - 1);
        end else begin
          r.outcome = foc_pkg::OUT_UNRES;
        end
      end
      expected_results.push_back(r);
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_result(logic [1:0] outcome, logic [foc_pkg::HandleW-1:0] handle,
                      logic [foc_pkg::SlotW-1:0] slot);
      lookup_result_t want;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result with no request pending: outcome %0d handle %h slot %0d",
                                  outcome, handle, slot));
        return;
      end
      want = expected_results.pop_front();
      if (outcome !== want.outcome)
        report_mismatch($sformatf("outcome %0d, want %0d", outcome, want.outcome));
      if (handle !== want.handle)
        report_mismatch($sformatf("handle_out %h, want %h", handle, want.handle));
      if (slot !== want.slot)
        report_mismatch($sformatf("slot %0d, want %0d", slot, want.slot));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  foc_req_if req ();
  foc_rsp_if rsp ();

  frequency_ordered_id_cache #(
    .ENTRIES(Entries)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .rsp_o (rsp)
  );

  lookup_scoreboard           cache_sb = new();
  bit                         idle_on = 1'b1;
  bit                         hold_pending = 1'b0;
  int unsigned                send_calm = 0;
  int unsigned                recv_calm = 0;
  logic [foc_pkg::IdentW-1:0] id_pool[PoolSize];

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  initial begin
    req.valid       = 1'b0;
    req.ident       = '0;
    req.resolved    = 1'b0;
    req.name_handle = '0;
    rsp.ready       = 1'b0;
    rst_ni          = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
  end

  function automatic int unsigned idle_len(ref int unsigned calm);
    int unsigned r;
    if (!idle_on) return 0;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task send_lookup(logic [foc_pkg::IdentW-1:0] ident, logic resolved,
                   logic [foc_pkg::HandleW-1:0] handle);
    int unsigned n;
    n = idle_len(send_calm);
    if (n > 0) begin
      @(negedge clk_i);
      req.valid = 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    req.valid       = 1'b1;
    req.ident       = ident;
    req.resolved    = resolved;
    req.name_handle = handle;
    do @(posedge clk_i); while (!req.ready);
    cache_sb.note_request(ident, resolved, handle);
  endtask

  task send_random_lookup();
    int unsigned                r;
    int unsigned                k;
    logic [foc_pkg::IdentW-1:0] ident;
    r = $urandom_range(0, 99);
    if (r < 5) begin
      ident = '0;
    end else if (r < 12) begin
      ident = $urandom;
    end else begin
      k     = $urandom_range(0, $urandom_range(0, PoolSize - 1));
      ident = id_pool[k];
    end
    send_lookup(ident, $urandom_range(0, 9) != 0, foc_pkg::HandleW'($urandom));
  endtask

  // receiver: random back-pressure plus one long hold-off on request
  initial begin
    int unsigned n;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_pending) begin
        rsp.ready = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_pending = 1'b0;
      end
      n = idle_len(recv_calm);
      if (n > 0) begin
        rsp.ready = 1'b0;
        repeat (n) @(negedge clk_i);
      end
      rsp.ready = 1'b1;
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && rsp.valid && rsp.ready)
        cache_sb.check_result(rsp.outcome, rsp.handle_out, rsp.slot);
    end
  end

  initial begin
    logic [foc_pkg::IdentW-1:0] v;
    foreach (id_pool[i]) begin
      do v = $urandom; while (v == '0);
      id_pool[i] = v;
    end
    @(posedge rst_ni);

    send_lookup(32'h0000_0000, 1'b1, 16'hFFFF);
    send_lookup(32'h0000_0000, 1'b0, 16'h0000);
    send_lookup(32'hFFFF_FFFF, 1'b0, 16'hFFFF);
    send_lookup(32'hFFFF_FFFF, 1'b1, 16'hFFFF);
    send_lookup(32'hFFFF_FFFF, 1'b0, 16'h0000);
    send_lookup(32'h0000_0001, 1'b1, 16'h0000);
    send_lookup(32'h0000_0001, 1'b0, 16'h1234);
    send_lookup(32'h0000_0001, 1'b1, 16'hFFFF);
    send_lookup(32'h8000_0000, 1'b1, 16'h8000);
    send_lookup(32'hFFFF_FFFF, 1'b0, 16'h0001);
    send_lookup(32'h5555_5555, 1'b1, 16'h5555);
    send_lookup(32'hAAAA_AAAA, 1'b1, 16'hAAAA);
    send_lookup(32'hAAAA_AAAA, 1'b0, 16'h0000);
    send_lookup(32'h5555_5555, 1'b0, 16'h0000);
    send_lookup(32'h0000_0001, 1'b0, 16'h0000);
    send_lookup(32'h0000_0001, 1'b0, 16'h0000);
    send_lookup(32'hFFFF_FFFF, 1'b1, 16'h7FFF);

    for (int i = 0; i < RandomReqs; i++) begin
      if (i == RandomReqs / 3) hold_pending = 1'b1;
      send_random_lookup();
    end

    // hammer two entries at full rate
    idle_on = 1'b0;
    send_lookup(32'h1234_5678, 1'b1, 16'hC0DE);
    for (int i = 0; i < SatHits; i++) send_lookup(32'h1234_5678, 1'b0, 16'h0000);
    send_lookup(32'hCAFE_0001, 1'b1, 16'hBEEF);
    for (int i = 0; i < SatHits; i++) send_lookup(32'hCAFE_0001, 1'b0, 16'h0000);
    idle_on = 1'b1;

    @(negedge clk_i);
    req.valid = 1'b0;
    while (cache_sb.expected_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (cache_sb.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("TEST FAILED");
    $finish;
  end

endmodule
